/* hw/rtl/dq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared widths, operation codes and status codes for the deque block.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_MIN        = 3'd4;
    localparam logic [OP_W-1:0] OP_MAX        = 3'd5;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd6;
    localparam logic [OP_W-1:0] OP_DUMP       = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

/* hw/rtl/dq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram
// Element ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [dq_pkg::VALUE_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [dq_pkg::VALUE_W-1:0] rdata
);
    import dq_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/dq_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_out
// Output word register; frees the core while a result waits downstream.
// ----------------------------------------------------------------------------
module dq_out #(
    parameter int CW    = 5,
    parameter int OUT_W = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [dq_pkg::STATUS_W-1:0] ld_status,
    input  logic [CW-1:0]               ld_count,
    input  logic [dq_pkg::VALUE_W-1:0]  ld_value,
    input  logic                        ld_found,
    input  logic                        ld_last,
    output logic                        free,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_W-1:0]            m_tdata,
    output logic                        m_tlast
);
    import dq_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [CW-1:0]       count_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                found_reg;
    logic                last_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= ld_status;
            count_reg  <= ld_count;
            value_reg  <= ld_value;
            found_reg  <= ld_found;
            last_reg   <= ld_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_W'({found_reg, value_reg, count_reg, status_reg});
    assign m_tlast  = last_reg;

endmodule

/* hw/rtl/dq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// Ring pointers, operation decode and the element walk for min, max, search
// and dump.
// ----------------------------------------------------------------------------
module dq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [dq_pkg::OP_W-1:0]     in_op,
    input  logic [dq_pkg::VALUE_W-1:0]  in_value,
    input  logic                        out_free,
    output logic                        load,
    output logic [dq_pkg::STATUS_W-1:0] ld_status,
    output logic [CW-1:0]               ld_count,
    output logic [dq_pkg::VALUE_W-1:0]  ld_value,
    output logic                        ld_found,
    output logic                        ld_last,
    output logic                        ram_we,
    output logic [AW-1:0]               ram_waddr,
    output logic [dq_pkg::VALUE_W-1:0]  ram_wdata,
    output logic                        ram_re,
    output logic [AW-1:0]               ram_raddr,
    input  logic [dq_pkg::VALUE_W-1:0]  ram_rdata
);
    import dq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [1:0]          state_reg,  state_next;
    logic [AW-1:0]       front_reg,  front_next;
    logic [CW-1:0]       cnt_reg,    cnt_next;
    logic [OP_W-1:0]     op_reg,     op_next;
    logic [VALUE_W-1:0]  key_reg,    key_next;
    logic [AW-1:0]       rp_reg,     rp_next;
    logic [CW-1:0]       k_reg,      k_next;
    logic                pend_reg,   pend_next;
    logic                first_reg,  first_next;
    logic [VALUE_W-1:0]  best_reg,   best_next;
    logic                hit_reg,    hit_next;
    logic [STATUS_W-1:0] rstat_reg,  rstat_next;
    logic [VALUE_W-1:0]  rval_reg,   rval_next;
    logic                rfound_reg, rfound_next;

    logic          accept;
    logic          is_dump;
    logic          consume;
    logic          issue;
    logic          walk_end;
    logic          take;
    logic          hit_now;
    logic [AW:0]   back_sum;
    logic [AW-1:0] back_slot;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] rp_inc;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign back_sum  = (AW+1)'(front_reg) + (AW+1)'(cnt_reg);
    assign back_slot = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                    : back_sum[AW-1:0];
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - AW'(1);
    assign rp_inc    = (rp_reg == LAST_SLOT) ? '0 : rp_reg + AW'(1);

    assign is_dump  = (op_reg == OP_DUMP);
    assign consume  = (state_reg == S_SCAN) && pend_reg && (!is_dump || out_free);
    assign issue    = (state_reg == S_SCAN) && (k_reg < cnt_reg) && (!pend_reg || consume);
    assign walk_end = (k_reg == cnt_reg);
    assign hit_now  = (ram_rdata == key_reg);

    always_comb
    begin
        take = 1'b0;
        if (first_reg)
        begin
            take = 1'b1;
        end
        else if (op_reg == OP_MIN)
        begin
            take = $signed(ram_rdata) < $signed(best_reg);
        end
        else
        begin
            take = $signed(best_reg) < $signed(ram_rdata);
        end
    end

    assign ram_re    = issue;
    assign ram_raddr = rp_reg;

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        rp_next     = rp_reg;
        k_next      = k_reg;
        pend_next   = pend_reg;
        first_next  = first_reg;
        best_next   = best_reg;
        hit_next    = hit_reg;
        rstat_next  = rstat_reg;
        rval_next   = rval_reg;
        rfound_next = rfound_reg;
        ram_we      = 1'b0;
        ram_waddr   = back_slot;
        ram_wdata   = in_value;
        load        = 1'b0;
        ld_status   = rstat_reg;
        ld_count    = cnt_reg;
        ld_value    = rval_reg;
        ld_found    = rfound_reg;
        ld_last     = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_op;
                    key_next    = in_value;
                    rstat_next  = ST_OK;
                    rval_next   = '0;
                    rfound_next = 1'b0;
                    state_next  = S_HOLD;
                    case (in_op) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (cnt_reg == FULL_CNT)
                            begin
                                rstat_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                                if (in_op == OP_PUSH_FRONT)
                                begin
                                    ram_waddr  = front_dec;
                                    front_next = front_dec;
                                end
                            end
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rstat_next = ST_EMPTY;
                            end
                            else if (in_op == OP_POP_FRONT)
                            begin
                                front_next = (front_reg == LAST_SLOT) ? '0
                                                                      : front_reg + AW'(1);
                                cnt_next   = cnt_reg - CW'(1);
                            end
                            else if (in_op == OP_POP_BACK)
                            begin
                                cnt_next = cnt_reg - CW'(1);
                            end
                            else
                            begin
                                rp_next    = front_reg;
                                k_next     = '0;
                                pend_next  = 1'b0;
                                first_next = 1'b1;
                                hit_next   = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (issue)
                begin
                    rp_next = rp_inc;
                    k_next  = k_reg + CW'(1);
                end
                if (consume)
                begin
                    first_next = 1'b0;
                    if (take)
                    begin
                        best_next = ram_rdata;
                    end
                    if (hit_now)
                    begin
                        hit_next = 1'b1;
                    end
                    if (is_dump)
                    begin
                        load      = 1'b1;
                        ld_status = ST_OK;
                        ld_value  = ram_rdata;
                        ld_found  = 1'b0;
                        ld_last   = walk_end;
                        if (walk_end)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else if (walk_end)
                    begin
                        rstat_next  = ST_OK;
                        rval_next   = (op_reg == OP_SEARCH) ? '0 : best_next;
                        rfound_next = (op_reg == OP_SEARCH) && hit_next;
                        state_next  = S_HOLD;
                    end
                end
                pend_next = issue || (pend_reg && !consume);
            end

            S_HOLD:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        rp_reg     <= rp_next;
        first_reg  <= first_next;
        best_reg   <= best_next;
        hit_reg    <= hit_next;
        rstat_reg  <= rstat_next;
        rval_reg   <= rval_next;
        rfound_reg <= rfound_next;
    end

endmodule

/* hw/rtl/deque_with_min_max_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_min_max_search
// Bounded double-ended queue of signed 32-bit words with min, max, search
// and dump.
// ----------------------------------------------------------------------------
// The elements sit in a DEPTH-entry ring memory with one read port and
// registered read data; front pointer and count live in registers. One
// operation is in progress at a time. Push and pop update the store on
// accept, wait in the hold state until the output register is free, then
// load their result and return to idle. Min, max and search walk the held
// elements through the read port, one per cycle, then hold and load the
// result in the same way. Dump streams one element per cycle once the
// first read returns, while the output register is free. A result word
// sits in an output register, so the next operation is accepted while it
// waits. Popping or querying an empty store returns status empty; pushing
// into a full store returns status full.
// ----------------------------------------------------------------------------
module deque_with_min_max_search #(
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [dq_pkg::VALUE_W-1:0]           s_tdata,  // value
    input  logic [dq_pkg::OP_W-1:0]              s_tuser,  // op
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // status, count, result_value, found, zero pad
    output logic [((dq_pkg::STATUS_W + $clog2(DEPTH + 1) + dq_pkg::VALUE_W + 1 + 7) / 8) * 8 - 1:0]
                                                 m_tdata,
    output logic                                 m_tlast   // last
);
    import dq_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = ((STATUS_W + CW + VALUE_W + 1 + 7) / 8) * 8;

    logic                out_free;
    logic                load;
    logic [STATUS_W-1:0] ld_status;
    logic [CW-1:0]       ld_count;
    logic [VALUE_W-1:0]  ld_value;
    logic                ld_found;
    logic                ld_last;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;

    dq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_value  (s_tdata),
        .out_free  (out_free),
        .load      (load),
        .ld_status (ld_status),
        .ld_count  (ld_count),
        .ld_value  (ld_value),
        .ld_found  (ld_found),
        .ld_last   (ld_last),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    dq_out #(
        .CW    (CW),
        .OUT_W (OUT_W)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .ld_status (ld_status),
        .ld_count  (ld_count),
        .ld_value  (ld_value),
        .ld_found  (ld_found),
        .ld_last   (ld_last),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* tb/tb_deque_with_min_max_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deque_with_min_max_search
// Self-checking bench for the bounded deque with min, max, search and dump.
// ----------------------------------------------------------------------------
// A short table of directed operations covers the empty store, the value
// extremes and a wrapped ring. Random phases follow that lean toward
// filling (reaching the full store), draining (reaching the empty store)
// or neither. Every accepted word feeds a local model of the deque. Each
// result word is checked field by field against the expected results:
// the table's for typed rows, the model's for the rest. Both stream sides
// idle at random. Once, the result side holds off long enough that the block stalls its input.
// ----------------------------------------------------------------------------
module tb_deque_with_min_max_search;

    import dq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int M_W         = ((STATUS_W + CNT_W + VALUE_W + 1 + 7) / 8) * 8;
    localparam int CNT_LSB     = STATUS_W;
    localparam int VAL_LSB     = STATUS_W + CNT_W;
    localparam int FOUND_BIT   = STATUS_W + CNT_W + VALUE_W;
    localparam int RAND_WORDS  = 395;
    localparam int PHASE_LEN   = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_SHOWN   = 10;

    typedef logic [OP_W-1:0] op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
        logic [VALUE_W-1:0]  value;
        logic                found;
        logic                last;
    } dq_result_t;

    typedef struct {
        op_t                op;
        logic [VALUE_W-1:0] value;
        bit                 typed;
        dq_result_t         res;
    } dq_row_t;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [VALUE_W-1:0] s_tdata = '0;   // value
    logic [OP_W-1:0]  s_tuser = '0;     // op
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [M_W-1:0]   m_tdata;          // status, count, result_value, found
    logic             m_tlast;          // last

    // deque model
    logic [VALUE_W-1:0] model_store [DEPTH];
    int                 model_front;
    int                 model_count;

    dq_result_t step_results[$];
    dq_result_t expected_results[$];
    dq_row_t    directed_rows[$];

    int mismatch_count = 0;
    int results_seen   = 0;
    bit tx_burst       = 1'b0;
    bit rx_burst       = 1'b0;
    bit pressure_done  = 1'b0;
    int rx_hold        = 0;
    int rx_cycles      = 0;

    deque_with_min_max_search #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int ring_slot(input int k);
        return (model_front + k) % DEPTH;
    endfunction

    function automatic dq_result_t make_result(input logic [STATUS_W-1:0] status,
                                               input logic [VALUE_W-1:0] value,
                                               input logic found, input logic last);
        dq_result_t r;
        r.status = status;
        r.count  = model_count[CNT_W-1:0];
        r.value  = value;
        r.found  = found;
        r.last   = last;
        return r;
    endfunction

    function automatic void predict_deque_op(input op_t op, input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] best;
        logic [VALUE_W-1:0] e;
        logic               hit;
        step_results.delete();
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            if (model_count >= DEPTH)
            begin
                step_results.push_back(make_result(ST_FULL, '0, 1'b0, 1'b1));
                return;
            end
            if (op == OP_PUSH_FRONT)
            begin
                model_front = (model_front + DEPTH - 1) % DEPTH;
                model_store[model_front] = v;
            end
            else
            begin
                model_store[ring_slot(model_count)] = v;
            end
            model_count++;
            step_results.push_back(make_result(ST_OK, '0, 1'b0, 1'b1));
            return;
        end
        if (model_count == 0)
        begin
            step_results.push_back(make_result(ST_EMPTY, '0, 1'b0, 1'b1));
            return;
        end
        case (op)
            OP_POP_FRONT:
            begin
                model_front = (model_front + 1) % DEPTH;
                model_count--;
                step_results.push_back(make_result(ST_OK, '0, 1'b0, 1'b1));
            end
            OP_POP_BACK:
            begin
                model_count--;
                step_results.push_back(make_result(ST_OK, '0, 1'b0, 1'b1));
            end
            OP_MIN, OP_MAX:
            begin
                best = model_store[ring_slot(0)];
                for (int k = 1; k < model_count; k++)
                begin
                    e = model_store[ring_slot(k)];
                    if (op == OP_MIN ? ($signed(e) < $signed(best))
                                     : ($signed(best) < $signed(e)))
                        best = e;
                end
                step_results.push_back(make_result(ST_OK, best, 1'b0, 1'b1));
            end
            OP_SEARCH:
            begin
                hit = 1'b0;
                for (int k = 0; k < model_count; k++)
                    if (model_store[ring_slot(k)] == v)
                        hit = 1'b1;
                step_results.push_back(make_result(ST_OK, '0, hit, 1'b1));
            end
            default:
            begin
                for (int k = 0; k < model_count; k++)
                    step_results.push_back(make_result(ST_OK, model_store[ring_slot(k)],
                                                       1'b0, k + 1 == model_count));
            end
        endcase
    endfunction

    function automatic void add_row(input op_t op, input logic [VALUE_W-1:0] value,
                                    input bit typed, input logic [STATUS_W-1:0] status,
                                    input int count, input logic [VALUE_W-1:0] rvalue,
                                    input logic found);
        dq_row_t row;
        row.op           = op;
        row.value        = value;
        row.typed        = typed;
        row.res.status   = status;
        row.res.count    = count[CNT_W-1:0];
        row.res.value    = rvalue;
        row.res.found    = found;
        row.res.last     = 1'b1;
        directed_rows.push_back(row);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input op_t op, input logic [VALUE_W-1:0] value,
                             input bit typed, input dq_result_t typed_res);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predict_deque_op(op, value);
        if (typed)
            expected_results.push_back(typed_res);
        else
            foreach (step_results[i])
                expected_results.push_back(step_results[i]);
    endtask

    task automatic idle_tx();
        int gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_word();
        dq_result_t got;
        dq_result_t want;
        got.status = m_tdata[STATUS_W-1:0];
        got.count  = m_tdata[CNT_LSB +: CNT_W];
        got.value  = m_tdata[VAL_LSB +: VALUE_W];
        got.found  = m_tdata[FOUND_BIT];
        got.last   = m_tlast;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
                $display("unexpected word: status=%0d count=%0d value=%0d found=%b last=%b",
                         got.status, got.count, $signed(got.value), got.found, got.last);
            return;
        end
        want = expected_results.pop_front();
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
            begin
                $display("mismatch: expected status=%0d count=%0d value=%0d found=%b last=%b",
                         want.status, want.count, $signed(want.value), want.found,
                         want.last);
                $display("          got      status=%0d count=%0d value=%0d found=%b last=%b",
                         got.status, got.count, $signed(got.value), got.found,
                         got.last);
            end
        end
    endtask

    // result side: check, then decide next tready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid === 1'b1 && m_tready)
                check_word();
            rx_cycles++;
            if (rx_cycles % 128 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (!pressure_done && results_seen >= 60)
            begin
                pressure_done = 1'b1;
                rx_hold = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (rx_burst)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                rx_hold = pick_gap();
                if (rx_hold > 0)
                begin
                    rx_hold--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        phase_t             phase;
        op_t                op;
        logic [VALUE_W-1:0] value;
        dq_result_t         none;
        int                 r;

        none = '0;
        model_front = 0;
        model_count = 0;
        foreach (model_store[i])
            model_store[i] = '0;

        // empty store
        add_row(OP_POP_FRONT, 32'h1234_5678, 1, ST_EMPTY, 0, '0, 1'b0);
        add_row(OP_POP_BACK,  '0,            1, ST_EMPTY, 0, '0, 1'b0);
        add_row(OP_MIN,       '0,            1, ST_EMPTY, 0, '0, 1'b0);
        add_row(OP_MAX,       '0,            1, ST_EMPTY, 0, '0, 1'b0);
        add_row(OP_SEARCH,    '0,            1, ST_EMPTY, 0, '0, 1'b0);
        add_row(OP_DUMP,      '1,            1, ST_EMPTY, 0, '0, 1'b0);
        // extremes; push front wraps the ring below slot zero
        add_row(OP_PUSH_BACK,  32'h7fff_ffff, 1, ST_OK, 1, '0, 1'b0);
        add_row(OP_PUSH_FRONT, 32'h8000_0000, 1, ST_OK, 2, '0, 1'b0);
        add_row(OP_MIN,        '0,            1, ST_OK, 2, 32'h8000_0000, 1'b0);
        add_row(OP_MAX,        '0,            1, ST_OK, 2, 32'h7fff_ffff, 1'b0);
        add_row(OP_SEARCH,     32'h8000_0000, 1, ST_OK, 2, '0, 1'b1);
        add_row(OP_SEARCH,     '0,            1, ST_OK, 2, '0, 1'b0);
        add_row(OP_PUSH_BACK,  '0,            0, ST_OK, 0, '0, 1'b0);
        add_row(OP_SEARCH,     '1,            0, ST_OK, 0, '0, 1'b0);
        add_row(OP_DUMP,       '0,            0, ST_OK, 0, '0, 1'b0);
        add_row(OP_POP_FRONT,  '0,            1, ST_OK, 2, '0, 1'b0);
        add_row(OP_POP_BACK,   '0,            1, ST_OK, 1, '0, 1'b0);
        add_row(OP_POP_BACK,   '0,            1, ST_OK, 0, '0, 1'b0);
        add_row(OP_DUMP,       '0,            1, ST_EMPTY, 0, '0, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].res);
            idle_tx();
        end

        phase = PH_MIXED;
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                phase = phase_t'($urandom_range(0, 2));
                tx_burst = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            case (phase)
                PH_FILL:
                    if (r < 75)
                        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                    else if (r < 85)
                        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                    else
                        op = op_t'($urandom_range(OP_MIN, OP_DUMP));
                PH_DRAIN:
                    if (r < 20)
                        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                    else if (r < 70)
                        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                    else
                        op = op_t'($urandom_range(OP_MIN, OP_DUMP));
                default:
                    op = op_t'($urandom_range(0, 7));
            endcase
            value = pick_value();
            // half the searches look for a key that is held
            if (op == OP_SEARCH && model_count > 0 && $urandom_range(0, 1))
                value = model_store[ring_slot($urandom_range(0, model_count - 1))];
            send_word(op, value, 1'b0, none);
            idle_tx();
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/dq_pkg.sv
hw/rtl/dq_ram.sv
hw/rtl/dq_out.sv
hw/rtl/dq_ctrl.sv
hw/rtl/deque_with_min_max_search.sv
tb/tb_deque_with_min_max_search.sv
